// ===== rtl/stereo_poly_predictor_encoder_core_defines.svh =====
// Assertion macros shared by the stereo predictor encoder checker.
`ifndef STEREO_POLY_PREDICTOR_ENCODER_CORE_DEFINES_SVH
`define STEREO_POLY_PREDICTOR_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define SPP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spp_enc: same-cycle check failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define SPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spp_enc: next-cycle check failed");

`endif

// ===== rtl/spp_enc_pkg.sv =====
// Package: constants and register codes of the stereo predictor encoder.
`timescale 1ns / 1ps
`default_nettype none

package spp_enc_pkg;

    localparam int SAMPLE_WIDTH_DEFAULT = 16;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam int MODE_WIDTH     = 2;
    localparam int LOST_WIDTH     = 5;
    localparam int COUNT_WIDTH    = 16;
    localparam int SUM_WIDTH      = 32;
    localparam int ORDER_WIDTH    = 2;

    typedef logic [MODE_WIDTH-1:0]      mode_t;
    typedef logic [ORDER_WIDTH-1:0]     order_t;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    // Configuration register indexes
    localparam cfg_index_t REG_CHANNEL_MODE    = 3'd0;
    localparam cfg_index_t REG_LOSSY_ENABLE    = 3'd1;
    localparam cfg_index_t REG_LOST_BITS       = 3'd2;
    localparam cfg_index_t REG_ADAPTIVE_ENABLE = 3'd3;
    localparam cfg_index_t REG_BLOCK_LENGTH    = 3'd4;

    // Decorrelation modes
    localparam mode_t MODE_INDEPENDENT = 2'd0;
    localparam mode_t MODE_MID_SIDE    = 2'd1;
    localparam mode_t MODE_RIGHT_SIDE  = 2'd2;
    localparam mode_t MODE_LEFT_SIDE   = 2'd3;

    // Predictor orders
    localparam order_t ORDER_ZERO  = 2'd0;
    localparam order_t ORDER_ONE   = 2'd1;
    localparam order_t ORDER_TWO   = 2'd2;
    localparam order_t ORDER_FULL  = 2'd3;

    localparam logic [COUNT_WIDTH-1:0] BLOCK_LENGTH_RESET = 16'd16;

endpackage

`default_nettype wire

// ===== rtl/stereo_poly_predictor_encoder_core.sv =====
// Top level: stereo decorrelation, third-order fixed predictor and block sums.
`timescale 1ns / 1ps
`default_nettype none

// Stereo fixed-polynomial predictor encoder. Each input transfer carries one
// stereo frame (right, left); each output transfer carries the x and y
// residuals, the predictor order used and, on the frame that closes an
// adaptive block, the block's sum of zigzag-mapped x residuals (block_sum is
// zero on every other frame). Throughput is one frame per clock cycle while
// the output is not stalled, set by the predictor state loop, which closes at
// the result register. A frame passes two registers: the input register,
// loaded at the input transfer, and the result register, which also commits the
// predictor state. With the result register free, the frame moves on from the
// input register into the result register, which raises out_valid. The input
// register drains into the result register whenever the result is empty or
// being taken, so a new frame can be accepted while a finished result waits.
// The first three frames after reset give order 0, 1 and 2 residuals; every
// later frame gives order 3. Configuration writes take effect at once and must
// only be made while the block is idle. Lost-bit counts of SAMPLE_WIDTH-1 and
// above act as SAMPLE_WIDTH-1.
module stereo_poly_predictor_encoder_core #(
    parameter int SAMPLE_WIDTH = spp_enc_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    // configuration write port
    input  wire                                        cfg_we,
    input  wire  [spp_enc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire  [spp_enc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    // input channel
    input  wire                                        in_valid,
    output logic                                       in_ready,
    input  wire  signed [SAMPLE_WIDTH-1:0]             right_sample,
    input  wire  signed [SAMPLE_WIDTH-1:0]             left_sample,
    // output channel
    output logic                                       out_valid,
    input  wire                                        out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]             residual_x,
    output logic signed [SAMPLE_WIDTH-1:0]             residual_y,
    output logic [spp_enc_pkg::ORDER_WIDTH-1:0]        pred_order,
    output logic                                       block_done,
    output logic [spp_enc_pkg::SUM_WIDTH-1:0]          block_sum
);

    localparam int CW = spp_enc_pkg::COUNT_WIDTH;
    localparam int SW = spp_enc_pkg::SUM_WIDTH;
    localparam int LW = spp_enc_pkg::LOST_WIDTH;
    localparam logic [LW-1:0] MAX_SHIFT = LW'(SAMPLE_WIDTH - 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    spp_enc_pkg::mode_t channel_mode_reg;
    logic               lossy_enable_reg;
    logic [LW-1:0]      lost_bits_reg;
    logic               adaptive_enable_reg;
    logic [CW-1:0]      block_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_mode_reg    <= spp_enc_pkg::MODE_INDEPENDENT;
            lossy_enable_reg    <= 1'b0;
            lost_bits_reg       <= '0;
            adaptive_enable_reg <= 1'b0;
            block_length_reg    <= spp_enc_pkg::BLOCK_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                spp_enc_pkg::REG_CHANNEL_MODE:
                    channel_mode_reg <= cfg_data[spp_enc_pkg::MODE_WIDTH-1:0];
                spp_enc_pkg::REG_LOSSY_ENABLE:
                    lossy_enable_reg <= cfg_data[0];
                spp_enc_pkg::REG_LOST_BITS:
                    lost_bits_reg <= cfg_data[LW-1:0];
                spp_enc_pkg::REG_ADAPTIVE_ENABLE:
                    adaptive_enable_reg <= cfg_data[0];
                spp_enc_pkg::REG_BLOCK_LENGTH:
                    block_length_reg <= cfg_data[CW-1:0];
                default:
                    ; // writes beyond the register list are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register: hold one frame until the result register is free
    // ---------------------------------------------------------------
    logic                           s1_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_right_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_left_reg;
    logic                           advance;
    logic                           in_xfer;

    // Move the held frame into the result stage when the output is empty
    // or its current result is transferred this cycle.
    assign advance  = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_right_reg <= right_sample;
            s1_left_reg  <= left_sample;
        end
    end

    // ---------------------------------------------------------------
    // Decorrelation
    // ---------------------------------------------------------------
    logic signed [SAMPLE_WIDTH:0]   pair_sum;
    logic signed [SAMPLE_WIDTH:0]   pair_sum_adj;
    logic signed [SAMPLE_WIDTH-1:0] mid_val;
    logic signed [SAMPLE_WIDTH-1:0] side_val;
    logic signed [SAMPLE_WIDTH-1:0] x_raw;
    logic signed [SAMPLE_WIDTH-1:0] y_raw;
    logic [LW-1:0]                  shift_amt;
    logic signed [SAMPLE_WIDTH-1:0] x_val;
    logic signed [SAMPLE_WIDTH-1:0] y_val;

    always_comb
    begin
        // Sum one bit wider; add one when negative so the halving truncates
        // toward zero rather than toward minus infinity.
        pair_sum     = {s1_right_reg[SAMPLE_WIDTH-1], s1_right_reg}
                     + {s1_left_reg[SAMPLE_WIDTH-1], s1_left_reg};
        pair_sum_adj = pair_sum + {{SAMPLE_WIDTH{1'b0}}, pair_sum[SAMPLE_WIDTH]};
        mid_val      = pair_sum_adj[SAMPLE_WIDTH:1];
        side_val     = s1_left_reg - s1_right_reg;  // wraps at sample width

        unique case (channel_mode_reg)
            spp_enc_pkg::MODE_MID_SIDE:
            begin
                x_raw = mid_val;
                y_raw = side_val;
            end
            spp_enc_pkg::MODE_RIGHT_SIDE:
            begin
                x_raw = s1_right_reg;
                y_raw = side_val;
            end
            spp_enc_pkg::MODE_LEFT_SIDE:
            begin
                x_raw = s1_left_reg;
                y_raw = side_val;
            end
            default:
            begin
                x_raw = s1_right_reg;
                y_raw = s1_left_reg;
            end
        endcase

        // Saturate the shift so an oversized count gives 0 or -1.
        shift_amt = (lost_bits_reg > MAX_SHIFT) ? MAX_SHIFT : lost_bits_reg;
        if (lossy_enable_reg)
        begin
            x_val = x_raw >>> shift_amt;
            y_val = y_raw >>> shift_amt;
        end
        else
        begin
            x_val = x_raw;
            y_val = y_raw;
        end
    end

    // ---------------------------------------------------------------
    // Fixed polynomial predictors, all differences wrap at sample width
    // ---------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] prev_level_x_reg, prev_diff1_x_reg, prev_diff2_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_level_y_reg, prev_diff1_y_reg, prev_diff2_y_reg;
    logic signed [SAMPLE_WIDTH-1:0] d1_x, d2_x, d3_x, d1_y, d2_y, d3_y;
    logic signed [SAMPLE_WIDTH-1:0] rx_next, ry_next;
    spp_enc_pkg::order_t            warmup_reg;

    always_comb
    begin
        d1_x = x_val - prev_level_x_reg;
        d2_x = d1_x - prev_diff1_x_reg;
        d3_x = d2_x - prev_diff2_x_reg;
        d1_y = y_val - prev_level_y_reg;
        d2_y = d1_y - prev_diff1_y_reg;
        d3_y = d2_y - prev_diff2_y_reg;

        unique case (warmup_reg)
            spp_enc_pkg::ORDER_ZERO:
            begin
                rx_next = x_val;
                ry_next = y_val;
            end
            spp_enc_pkg::ORDER_ONE:
            begin
                rx_next = d1_x;
                ry_next = d1_y;
            end
            spp_enc_pkg::ORDER_TWO:
            begin
                rx_next = d2_x;
                ry_next = d2_y;
            end
            default:
            begin
                rx_next = d3_x;
                ry_next = d3_y;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Adaptive block sums of zigzag-mapped x residuals
    // ---------------------------------------------------------------
    logic [SAMPLE_WIDTH-1:0] rx_dbl;
    logic [SAMPLE_WIDTH-1:0] zig_val;
    logic [CW-1:0]           block_count_reg;
    logic [CW-1:0]           count_inc;
    logic [SW-1:0]           running_sum_reg;
    logic [SW-1:0]           sum_inc;
    logic                    accumulate;
    logic                    done_next;

    always_comb
    begin
        // Low bits of 2*r; map r>0 to 2r-1 and r<=0 to -2r, kept to width.
        rx_dbl = {rx_next[SAMPLE_WIDTH-2:0], 1'b0};
        if (!rx_next[SAMPLE_WIDTH-1] && (rx_next != '0))
        begin
            zig_val = rx_dbl - 1'b1;
        end
        else
        begin
            zig_val = '0 - rx_dbl;
        end
        accumulate = (warmup_reg == spp_enc_pkg::ORDER_FULL) && adaptive_enable_reg;
        count_inc  = block_count_reg + 1'b1;
        sum_inc    = running_sum_reg + SW'(zig_val);
        done_next  = accumulate && (count_inc == block_length_reg);
    end

    // ---------------------------------------------------------------
    // State commit and result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_x_reg <= '0;
            prev_diff1_x_reg <= '0;
            prev_diff2_x_reg <= '0;
            prev_level_y_reg <= '0;
            prev_diff1_y_reg <= '0;
            prev_diff2_y_reg <= '0;
            warmup_reg       <= spp_enc_pkg::ORDER_ZERO;
            block_count_reg  <= '0;
            running_sum_reg  <= '0;
        end
        else if (advance)
        begin
            prev_level_x_reg <= x_val;
            prev_diff1_x_reg <= d1_x;
            prev_diff2_x_reg <= d2_x;
            prev_level_y_reg <= y_val;
            prev_diff1_y_reg <= d1_y;
            prev_diff2_y_reg <= d2_y;
            if (warmup_reg != spp_enc_pkg::ORDER_FULL)
            begin
                warmup_reg <= warmup_reg + 1'b1;
            end
            if (done_next)
            begin
                block_count_reg <= '0;
                running_sum_reg <= '0;
            end
            else if (accumulate)
            begin
                block_count_reg <= count_inc;
                running_sum_reg <= sum_inc;
            end
        end
    end

    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            residual_x <= rx_next;
            residual_y <= ry_next;
            pred_order <= warmup_reg;
            block_done <= done_next;
            block_sum  <= done_next ? sum_inc : '0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/spp_enc_checker.sv =====
// Checker on the encoder's ports, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_poly_predictor_encoder_core_defines.svh"

module spp_enc_checker #(
    parameter int SAMPLE_WIDTH = spp_enc_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input wire                                   clk,
    input wire                                   rst_n,
    input wire                                   in_ready,
    input wire                                   out_valid,
    input wire                                   out_ready,
    input wire [SAMPLE_WIDTH-1:0]                residual_x,
    input wire [spp_enc_pkg::ORDER_WIDTH-1:0]    pred_order,
    input wire                                   block_done,
    input wire [spp_enc_pkg::SUM_WIDTH-1:0]      block_sum
);

    // A stalled result holds its value.
    `SPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(residual_x))

    // Input back-pressure only comes from a stalled output.
    `SPP_ASSERT_NOW(a_ready_cause, !in_ready, out_valid && !out_ready)

    // Blocks close only on full-order frames.
    `SPP_ASSERT_NOW(a_done_order, out_valid && block_done, pred_order == spp_enc_pkg::ORDER_FULL)

    // The sum field is zero unless a block closes.
    `SPP_ASSERT_NOW(a_sum_zero, out_valid && !block_done, block_sum == '0)

endmodule

bind stereo_poly_predictor_encoder_core spp_enc_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_spp_enc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .residual_x (residual_x),
    .pred_order (pred_order),
    .block_done (block_done),
    .block_sum  (block_sum)
);

`default_nettype wire

// ===== bench/tb_stereo_poly_predictor_encoder_core.sv =====
// Testbench: stereo predictor encoder core checked against a cycle-free predictor.
`timescale 1ns / 1ps

// The bench drives stereo frames on the input channel and takes results from the
// output channel, both with valid/ready handshakes. A behavioral predictor holds
// its own copy of the decorrelation settings and the per-channel difference state.
// It runs once per accepted input transfer and queues the expected result. Every
// output transfer is compared field by field against the oldest queued result.
//
// Stimulus runs in three parts:
//   - a short directed script: field extremes, every decorrelation mode, large
//     shifts, lossy off with a stale shift count, zigzag wrap, and adaptive hold;
//   - random phases with fresh register settings each time;
//   - a short streaming phase with a zero block length, which keeps the block
//     open, then a length lowered below the running count, so the count rises on.
module tb_stereo_poly_predictor_encoder_core;

    localparam int SW             = spp_enc_pkg::SAMPLE_WIDTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_FRAMES   = 56;

    typedef struct {
        logic signed [SW-1:0]              residual_x;
        logic signed [SW-1:0]              residual_y;
        spp_enc_pkg::order_t               order;
        logic                              done;
        logic [spp_enc_pkg::SUM_WIDTH-1:0] sum;
    } frame_result_t;

    // Kinds of rows in the directed script. STEP_STEER picks the right sample so
    // that the x residual lands on the value in field a.
    typedef enum logic [1:0] {STEP_FRAME, STEP_STEER, STEP_CFG} step_kind_t;

    typedef struct packed {
        step_kind_t          kind;
        logic [15:0]         a;
        logic [15:0]         b;
        logic                pinned;
        logic [15:0]         want_x;
        logic [15:0]         want_y;
        spp_enc_pkg::order_t want_order;
    } step_t;

    // Handshake pacing shared by both channels.
    typedef enum {PACE_STEADY, PACE_BURSTY, PACE_SPARSE} pace_t;

    logic                                     clk = 1'b0;
    logic                                     rst_n;
    logic                                     cfg_we;
    spp_enc_pkg::cfg_index_t                  cfg_index;
    logic [spp_enc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data;
    logic                                     in_valid;
    logic                                     in_ready;
    logic signed [SW-1:0]                     right_sample;
    logic signed [SW-1:0]                     left_sample;
    logic                                     out_valid;
    logic                                     out_ready;
    logic signed [SW-1:0]                     residual_x;
    logic signed [SW-1:0]                     residual_y;
    logic [spp_enc_pkg::ORDER_WIDTH-1:0]      pred_order;
    logic                                     block_done;
    logic [spp_enc_pkg::SUM_WIDTH-1:0]        block_sum;

    stereo_poly_predictor_encoder_core #(
        .SAMPLE_WIDTH (SW)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .right_sample (right_sample),
        .left_sample  (left_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .residual_x   (residual_x),
        .residual_y   (residual_y),
        .pred_order   (pred_order),
        .block_done   (block_done),
        .block_sum    (block_sum)
    );

    // 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow copy of the configuration registers.
    spp_enc_pkg::mode_t                  cur_mode;
    logic                                cur_lossy;
    logic [spp_enc_pkg::LOST_WIDTH-1:0]  cur_lost;
    logic                                cur_adaptive;
    logic [spp_enc_pkg::COUNT_WIDTH-1:0] cur_blen;

    // Predictor state: last level and first and second differences per channel.
    logic signed [SW-1:0]                lvl_x, d1_x, d2_x;
    logic signed [SW-1:0]                lvl_y, d1_y, d2_y;
    spp_enc_pkg::order_t                 warm_order;
    logic [spp_enc_pkg::COUNT_WIDTH-1:0] blk_count;
    logic [spp_enc_pkg::SUM_WIDTH-1:0]   acc_sum;

    frame_result_t expected_residuals [$];

    // Fixed expectation for the next input transfer, set by the driver at the
    // falling edge and read by the monitor at the rising edge.
    logic          pin_valid;
    frame_result_t pin_result;

    pace_t pace;
    int    errors;
    int    frames_accepted;
    int    results_checked;
    int    blocks_closed;
    int    sum_wraps;
    int    zigzag_wraps;
    int    idle_cycles;

    logic [15:0] extremes [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};

    // Directed script. Expected values are typed in only for the first two frames
    // after reset (order 0 passes the samples through, order 1 is a plain wrapped
    // difference); the rest go through the predictor.
    step_t script [0:35] = '{
        // order 0 straight after reset: residuals equal the samples
        '{STEP_FRAME, 16'h7fff, 16'h8000, 1'b1, 16'h7fff, 16'h8000, spp_enc_pkg::ORDER_ZERO},
        // order 1 across the full range: both differences wrap
        '{STEP_FRAME, 16'h8000, 16'h7fff, 1'b1, 16'h0001, 16'hffff, spp_enc_pkg::ORDER_ONE},
        '{STEP_FRAME, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        '{STEP_FRAME, 16'h0001, 16'hffff, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        // one-frame blocks, mid-side with negative odd sums and full-range pairs
        '{STEP_CFG, 16'(spp_enc_pkg::REG_ADAPTIVE_ENABLE), 16'd1,
          1'b0, 16'h0, 16'h0, spp_enc_pkg::ORDER_ZERO},
        '{STEP_CFG, 16'(spp_enc_pkg::REG_BLOCK_LENGTH), 16'd1,
          1'b0, 16'h0, 16'h0, spp_enc_pkg::ORDER_ZERO},
        '{STEP_CFG, 16'(spp_enc_pkg::REG_CHANNEL_MODE), 16'(spp_enc_pkg::MODE_MID_SIDE),
          1'b0, 16'h0, 16'h0, spp_enc_pkg::ORDER_ZERO},
        '{STEP_FRAME, 16'hfffd, 16'h0000, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        '{STEP_FRAME, 16'h7fff, 16'h7fff, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        '{STEP_FRAME, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        '{STEP_FRAME, 16'h8000, 16'h7fff, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        '{STEP_CFG, 16'(spp_enc_pkg::REG_CHANNEL_MODE), 16'(spp_enc_pkg::MODE_RIGHT_SIDE),
          1'b0, 16'h0, 16'h0, spp_enc_pkg::ORDER_ZERO},
        '{STEP_FRAME, 16'h8000, 16'h7fff, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        '{STEP_FRAME, 16'h0064, 16'hff38, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        '{STEP_CFG, 16'(spp_enc_pkg::REG_CHANNEL_MODE), 16'(spp_enc_pkg::MODE_LEFT_SIDE),
          1'b0, 16'h0, 16'h0, spp_enc_pkg::ORDER_ZERO},
        '{STEP_FRAME, 16'h7fff, 16'h8000, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        '{STEP_FRAME, 16'h1234, 16'hedcb, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        // lossy with shift counts at the sample width, one below it, and small
        '{STEP_CFG, 16'(spp_enc_pkg::REG_LOSSY_ENABLE), 16'd1,
          1'b0, 16'h0, 16'h0, spp_enc_pkg::ORDER_ZERO},
        '{STEP_CFG, 16'(spp_enc_pkg::REG_LOST_BITS), 16'd16,
          1'b0, 16'h0, 16'h0, spp_enc_pkg::ORDER_ZERO},
        '{STEP_FRAME, 16'h8000, 16'h0005, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        '{STEP_FRAME, 16'h7fff, 16'hffff, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        '{STEP_CFG, 16'(spp_enc_pkg::REG_LOST_BITS), 16'd15,
          1'b0, 16'h0, 16'h0, spp_enc_pkg::ORDER_ZERO},
        '{STEP_FRAME, 16'h4000, 16'hc000, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        '{STEP_CFG, 16'(spp_enc_pkg::REG_LOST_BITS), 16'd1,
          1'b0, 16'h0, 16'h0, spp_enc_pkg::ORDER_ZERO},
        '{STEP_FRAME, 16'h7fff, 16'h8001, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        // lossy off: the stale shift count must be ignored
        '{STEP_CFG, 16'(spp_enc_pkg::REG_LOSSY_ENABLE), 16'd0,
          1'b0, 16'h0, 16'h0, spp_enc_pkg::ORDER_ZERO},
        '{STEP_FRAME, 16'h0003, 16'hfffd, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        // three-frame block with the most negative residual (zigzag wraps to 0)
        '{STEP_CFG, 16'(spp_enc_pkg::REG_CHANNEL_MODE), 16'(spp_enc_pkg::MODE_INDEPENDENT),
          1'b0, 16'h0, 16'h0, spp_enc_pkg::ORDER_ZERO},
        '{STEP_CFG, 16'(spp_enc_pkg::REG_BLOCK_LENGTH), 16'd3,
          1'b0, 16'h0, 16'h0, spp_enc_pkg::ORDER_ZERO},
        '{STEP_STEER, 16'h8000, 16'h0000, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        '{STEP_STEER, 16'h7fff, 16'hffff, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        '{STEP_STEER, 16'h8001, 16'h1111, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        // adaptive off: count and sum hold
        '{STEP_CFG, 16'(spp_enc_pkg::REG_ADAPTIVE_ENABLE), 16'd0,
          1'b0, 16'h0, 16'h0, spp_enc_pkg::ORDER_ZERO},
        '{STEP_STEER, 16'h7fff, 16'h2222, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO},
        '{STEP_CFG, 16'(spp_enc_pkg::REG_ADAPTIVE_ENABLE), 16'd1,
          1'b0, 16'h0, 16'h0, spp_enc_pkg::ORDER_ZERO},
        '{STEP_STEER, 16'h0001, 16'h3333, 1'b0, 16'h0000, 16'h0000, spp_enc_pkg::ORDER_ZERO}
    };

    // Arithmetic shift right; counts past SW-1 act as SW-1.
    function automatic logic signed [SW-1:0] drop_low_bits(
        input logic signed [SW-1:0] v,
        input logic [spp_enc_pkg::LOST_WIDTH-1:0] n);
        logic [spp_enc_pkg::LOST_WIDTH-1:0] s;
        s = (n > SW - 1) ? spp_enc_pkg::LOST_WIDTH'(SW - 1) : n;
        return v >>> s;
    endfunction

    // Advance one channel's difference chain and return the residual of the order.
    function automatic logic signed [SW-1:0] step_channel(input logic signed [SW-1:0] level,
                                                          input spp_enc_pkg::order_t ord,
                                                          inout logic signed [SW-1:0] lvl,
                                                          inout logic signed [SW-1:0] d1p,
                                                          inout logic signed [SW-1:0] d2p);
        logic signed [SW-1:0] d1, d2, d3;
        d1  = level - lvl;
        d2  = d1 - d1p;
        d3  = d2 - d2p;
        lvl = level;
        d1p = d1;
        d2p = d2;
        case (ord)
            spp_enc_pkg::ORDER_ZERO: return level;
            spp_enc_pkg::ORDER_ONE:  return d1;
            spp_enc_pkg::ORDER_TWO:  return d2;
            default:                 return d3;
        endcase
    endfunction

    // Predict the result of one frame and advance the predictor state.
    function automatic frame_result_t encode_frame(input logic signed [SW-1:0] r,
                                                   input logic signed [SW-1:0] l);
        frame_result_t res;
        logic signed [SW-1:0] x, y;
        int mid, zz;
        logic [spp_enc_pkg::SUM_WIDTH-1:0] mapped;
        mid = (int'(r) + int'(l)) / 2;
        case (cur_mode)
            spp_enc_pkg::MODE_MID_SIDE:
            begin
                x = mid[SW-1:0];
                y = l - r;
            end
            spp_enc_pkg::MODE_RIGHT_SIDE:
            begin
                x = r;
                y = l - r;
            end
            spp_enc_pkg::MODE_LEFT_SIDE:
            begin
                x = l;
                y = l - r;
            end
            default:
            begin
                x = r;
                y = l;
            end
        endcase
        if (cur_lossy)
        begin
            x = drop_low_bits(x, cur_lost);
            y = drop_low_bits(y, cur_lost);
        end
        res.order      = warm_order;
        res.residual_x = step_channel(x, warm_order, lvl_x, d1_x, d2_x);
        res.residual_y = step_channel(y, warm_order, lvl_y, d1_y, d2_y);
        res.done       = 1'b0;
        res.sum        = '0;
        if (warm_order != spp_enc_pkg::ORDER_FULL)
            warm_order = warm_order + 1'b1;
        else if (cur_adaptive)
        begin
            zz = (int'(res.residual_x) > 0) ? 2 * int'(res.residual_x) - 1
                                            : -2 * int'(res.residual_x);
            mapped = {16'd0, zz[SW-1:0]};
            if (res.residual_x == 16'sh8000)
                zigzag_wraps++;
            if (acc_sum + mapped < acc_sum)
                sum_wraps++;
            acc_sum   = acc_sum + mapped;
            blk_count = blk_count + 1'b1;
            if (blk_count == cur_blen)
            begin
                res.done  = 1'b1;
                res.sum   = acc_sum;
                acc_sum   = '0;
                blk_count = '0;
            end
        end
        return res;
    endfunction

    // Right sample that puts the x residual on target (x equals right, no shift).
    function automatic logic signed [SW-1:0] steer_right(input logic signed [SW-1:0] target);
        return target + lvl_x + d1_x + d2_x;
    endfunction

    // Idle length for either channel: mostly short, a few long.
    function automatic int idle_gap();
        int k;
        k = $urandom_range(0, 99);
        case (pace)
            PACE_STEADY: return 0;
            PACE_SPARSE: return ($urandom_range(0, 127) == 0) ? $urandom_range(1, 3) : 0;
            default:
            begin
                if (k < 50)      return 0;
                else if (k < 85) return $urandom_range(1, 3);
                else if (k < 97) return $urandom_range(4, 12);
                else             return $urandom_range(20, 60);
            end
        endcase
    endfunction

    // Offer one frame and hold it until the transfer; return at the next falling edge.
    task automatic push_frame(input logic [15:0] r, input logic [15:0] l,
                              input logic pinned, input frame_result_t want);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pin_valid    = pinned;
        pin_result   = want;
        in_valid     <= 1'b1;
        right_sample <= r;
        left_sample  <= l;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid, drain every expected result, then let the pipeline go quiet.
    task automatic settle();
        in_valid  <= 1'b0;
        pin_valid = 1'b0;
        while (expected_residuals.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write; the shadow copy follows it.
    task automatic write_reg(input spp_enc_pkg::cfg_index_t idx,
                             input logic [spp_enc_pkg::CFG_DATA_WIDTH-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            spp_enc_pkg::REG_CHANNEL_MODE:
                cur_mode     = val[spp_enc_pkg::MODE_WIDTH-1:0];
            spp_enc_pkg::REG_LOSSY_ENABLE:
                cur_lossy    = val[0];
            spp_enc_pkg::REG_LOST_BITS:
                cur_lost     = val[spp_enc_pkg::LOST_WIDTH-1:0];
            spp_enc_pkg::REG_ADAPTIVE_ENABLE:
                cur_adaptive = val[0];
            spp_enc_pkg::REG_BLOCK_LENGTH:
                cur_blen     = val[spp_enc_pkg::COUNT_WIDTH-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stream frames whose x residual is near full scale, so mapped values stay
    // close to the 16-bit maximum.
    task automatic stream_wide_residuals(input int n);
        int i;
        frame_result_t no_pin;
        no_pin.residual_x = '0;
        no_pin.residual_y = '0;
        no_pin.order      = spp_enc_pkg::ORDER_ZERO;
        no_pin.done       = 1'b0;
        no_pin.sum        = '0;
        for (i = 0; i < n; i++)
            push_frame(steer_right($urandom_range(0, 1) ? 16'sh7fff : 16'sh8001),
                       16'($urandom), 1'b0, no_pin);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Predict on every input transfer; check on every output transfer.
    always @(posedge clk)
    begin
        frame_result_t fresh;
        frame_result_t want;
        if (rst_n && in_valid && in_ready)
        begin
            fresh = encode_frame(right_sample, left_sample);
            if (pin_valid)
                expected_residuals.push_back(pin_result);
            else
                expected_residuals.push_back(fresh);
            frames_accepted++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_residuals.size() == 0)
            begin
                $display("%0t ns: result transfer with nothing expected, residual_x %0h",
                         $time, residual_x);
                errors++;
            end
            else
            begin
                want = expected_residuals.pop_front();
                check_field("residual_x", 32'(want.residual_x), 32'(residual_x));
                check_field("residual_y", 32'(want.residual_y), 32'(residual_y));
                check_field("pred_order", 32'(want.order), 32'(pred_order));
                check_field("block_done", 32'(want.done), 32'(block_done));
                check_field("block_sum", want.sum, block_sum);
                if (want.done)
                    blocks_closed++;
                results_checked++;
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no transfer for %0d cycles, %0d results still expected",
                     $time, idle_cycles, expected_residuals.size());
            $display("[stereo_poly_predictor_encoder_core] ERROR");
            $finish;
        end
    end

    // Result side: ready runs broken by stalls, paced like the input side.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ((pace == PACE_BURSTY) ? $urandom_range(1, 8) : $urandom_range(20, 200))
                @(negedge clk);
            stall = idle_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    initial
    begin
        int i, p, k;
        logic [15:0] r, l, last_r, last_l;
        frame_result_t blank, pinned;
        step_t row;

        // Known values on every input from time zero.
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = spp_enc_pkg::REG_CHANNEL_MODE;
        cfg_data     = '0;
        in_valid     = 1'b0;
        right_sample = '0;
        left_sample  = '0;
        pin_valid    = 1'b0;
        pace         = PACE_BURSTY;
        errors          = 0;
        frames_accepted = 0;
        results_checked = 0;
        blocks_closed   = 0;
        sum_wraps       = 0;
        zigzag_wraps    = 0;
        idle_cycles     = 0;

        // Reset values of the shadow registers and predictor state.
        cur_mode     = spp_enc_pkg::MODE_INDEPENDENT;
        cur_lossy    = 1'b0;
        cur_lost     = '0;
        cur_adaptive = 1'b0;
        cur_blen     = spp_enc_pkg::BLOCK_LENGTH_RESET;
        lvl_x = '0; d1_x = '0; d2_x = '0;
        lvl_y = '0; d1_y = '0; d2_y = '0;
        warm_order = spp_enc_pkg::ORDER_ZERO;
        blk_count  = '0;
        acc_sum    = '0;

        blank.residual_x = '0;
        blank.residual_y = '0;
        blank.order      = spp_enc_pkg::ORDER_ZERO;
        blank.done       = 1'b0;
        blank.sum        = '0;
        last_r = '0;
        last_l = '0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed script. Drain before every register write.
        for (i = 0; i < $size(script); i++)
        begin
            row = script[i];
            case (row.kind)
                STEP_CFG:
                begin
                    settle();
                    write_reg(row.a[spp_enc_pkg::CFG_INDEX_WIDTH-1:0], row.b);
                end
                STEP_STEER:
                    push_frame(steer_right(row.a), row.b, 1'b0, blank);
                default:
                begin
                    pinned            = blank;
                    pinned.residual_x = row.want_x;
                    pinned.residual_y = row.want_y;
                    pinned.order      = row.want_order;
                    push_frame(row.a, row.b, row.pinned, pinned);
                end
            endcase
        end

        // Random phases: fresh settings each time, extremes favored.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            pace = (p % 4 == 0) ? PACE_STEADY : PACE_BURSTY;
            write_reg(spp_enc_pkg::REG_CHANNEL_MODE, 16'($urandom_range(0, 3)));
            write_reg(spp_enc_pkg::REG_LOSSY_ENABLE, 16'($urandom_range(0, 1)));
            case ($urandom_range(0, 4))
                0:       write_reg(spp_enc_pkg::REG_LOST_BITS, 16'd0);
                1:       write_reg(spp_enc_pkg::REG_LOST_BITS, 16'd16);
                2:       write_reg(spp_enc_pkg::REG_LOST_BITS, 16'd15);
                default: write_reg(spp_enc_pkg::REG_LOST_BITS, 16'($urandom_range(0, 16)));
            endcase
            write_reg(spp_enc_pkg::REG_ADAPTIVE_ENABLE, 16'($urandom_range(0, 3) != 0));
            case ($urandom_range(0, 5))
                0:       write_reg(spp_enc_pkg::REG_BLOCK_LENGTH, 16'd1);
                1:       write_reg(spp_enc_pkg::REG_BLOCK_LENGTH, 16'hffff);
                default: write_reg(spp_enc_pkg::REG_BLOCK_LENGTH, 16'($urandom_range(2, 24)));
            endcase

            for (i = 0; i < PHASE_FRAMES; i++)
            begin
                k = $urandom_range(0, 15);
                if (k < 2 && !cur_lossy &&
                    (cur_mode == spp_enc_pkg::MODE_INDEPENDENT ||
                     cur_mode == spp_enc_pkg::MODE_RIGHT_SIDE))
                begin
                    // aim the x residual at a wrap point or a tiny value
                    case ($urandom_range(0, 3))
                        0:       r = steer_right(16'sh8000);
                        1:       r = steer_right(16'sh7fff);
                        2:       r = steer_right(16'sh8001);
                        default: r = steer_right(16'($urandom_range(0, 7)));
                    endcase
                    l = 16'($urandom);
                end
                else if (k < 4)
                begin
                    r = extremes[$urandom_range(0, 3)];
                    l = extremes[$urandom_range(0, 3)];
                end
                else if (k < 8)
                begin
                    // slow drift, so the higher orders see small residuals
                    r = last_r + 16'($urandom_range(0, 63)) - 16'd32;
                    l = last_l + 16'($urandom_range(0, 63)) - 16'd32;
                end
                else
                begin
                    r = 16'($urandom);
                    l = 16'($urandom);
                end
                last_r = r;
                last_l = l;
                push_frame(r, l, 1'b0, blank);
            end
        end

        // Open blocks: a zero block length keeps the block open, then a length
        // lowered below the running count leaves it open while the count rises.
        settle();
        pace = PACE_SPARSE;
        write_reg(spp_enc_pkg::REG_CHANNEL_MODE, 16'(spp_enc_pkg::MODE_INDEPENDENT));
        write_reg(spp_enc_pkg::REG_LOSSY_ENABLE, 16'd0);
        write_reg(spp_enc_pkg::REG_ADAPTIVE_ENABLE, 16'd1);
        write_reg(spp_enc_pkg::REG_BLOCK_LENGTH, 16'd0);
        stream_wide_residuals(24);
        settle();
        write_reg(spp_enc_pkg::REG_BLOCK_LENGTH, 16'd2);
        stream_wide_residuals(12);

        // Drain and let the pipeline go quiet before the verdict.
        settle();
        repeat (8) @(negedge clk);

        $display("Covered %0d frames in all four channel modes, lossy shifts 0 to 16,",
                 frames_accepted);
        $display("block lengths 0 to 65535: %0d results, %0d block sums, %0d zigzag wraps",
                 results_checked, blocks_closed, zigzag_wraps);
        $display("and %0d sum wraps, with stalls on both channels.", sum_wraps);
        if (errors == 0)
            $display("[stereo_poly_predictor_encoder_core] OK");
        else
            $display("[stereo_poly_predictor_encoder_core] ERROR");
        $finish;
    end

endmodule
